>>> src/tlv_element_encoder_assert.svh
// Assertion macros for the TLV element encoder.
`ifndef TLV_ELEMENT_ENCODER_ASSERT_SVH
`define TLV_ELEMENT_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

`define TLV_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tlv_element_encoder: check failed");

`define TLV_ASSERT_IMPLY(name, cond, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("tlv_element_encoder: check failed");

`define TLV_ASSERT_NEXT(name, cond, nxt) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("tlv_element_encoder: check failed");

`else

`define TLV_ASSERT_ALWAYS(name, expr)
`define TLV_ASSERT_IMPLY(name, cond, cons)
`define TLV_ASSERT_NEXT(name, cond, nxt)

`endif

`endif

>>> src/tlvenc_pkg.sv
// Types, codes and helpers for the TLV element encoder.
`default_nettype none

package tlvenc_pkg;

    localparam int MAX_DEPTH_DEFAULT = 8;
    localparam int MAX_BYTES         = 17;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 32;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] elem_prof;
        logic [31:0] elem_num;
        logic [63:0] value_bits;
        logic        bool_value;
        logic [31:0] string_length;
        logic [7:0]  payload_byte;
        logic [4:0]  container_type;
    } req_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [2:0]  status;
        logic [15:0] total_length;
    } rsp_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_INVALID   = 3'd1,
        STATUS_NO_SPACE  = 3'd2,
        STATUS_TOO_DEEP  = 3'd3,
        STATUS_BAD_STATE = 3'd4
    } status_t;

    localparam logic [3:0] KIND_BOOL     = 4'd0;
    localparam logic [3:0] KIND_NULL     = 4'd1;
    localparam logic [3:0] KIND_SIGNED   = 4'd2;
    localparam logic [3:0] KIND_UNSIGNED = 4'd3;
    localparam logic [3:0] KIND_TEXT     = 4'd4;
    localparam logic [3:0] KIND_BYTES    = 4'd5;
    localparam logic [3:0] KIND_PAYLOAD  = 4'd6;
    localparam logic [3:0] KIND_START    = 4'd7;
    localparam logic [3:0] KIND_END      = 4'd8;
    localparam logic [3:0] KIND_FINISH   = 4'd9;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMPLICIT_PROFILE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMPLICIT_ENABLE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY         = 2'd2;

    // tag control field
    localparam logic [7:0] TAG_ANON     = 8'h00;
    localparam logic [7:0] TAG_CONTEXT  = 8'h20;
    localparam logic [7:0] TAG_COMMON_2 = 8'h40;
    localparam logic [7:0] TAG_COMMON_4 = 8'h60;
    localparam logic [7:0] TAG_IMPL_2   = 8'h80;
    localparam logic [7:0] TAG_IMPL_4   = 8'hA0;
    localparam logic [7:0] TAG_FULL_6   = 8'hC0;
    localparam logic [7:0] TAG_FULL_8   = 8'hE0;

    // element types
    localparam logic [4:0] TYPE_SIGNED     = 5'h00;
    localparam logic [4:0] TYPE_UNSIGNED   = 5'h04;
    localparam logic [4:0] TYPE_BOOL_FALSE = 5'h08;
    localparam logic [4:0] TYPE_UTF8       = 5'h0C;
    localparam logic [4:0] TYPE_BYTES      = 5'h10;
    localparam logic [4:0] TYPE_NULL       = 5'h14;
    localparam logic [4:0] TYPE_STRUCT     = 5'h15;
    localparam logic [4:0] TYPE_LIST       = 5'h17;
    localparam logic [7:0] END_OF_CONTAINER = 8'h18;

    // narrowest width code: 0..3 for 1, 2, 4, 8 octets
    function automatic logic [1:0] int_code(input logic [63:0] v, input logic sgn);
        logic [1:0] c;
        if (sgn) begin
            if ((&v[63:7]) || !(|v[63:7]))
                c = 2'd0;
            else if ((&v[63:15]) || !(|v[63:15]))
                c = 2'd1;
            else if ((&v[63:31]) || !(|v[63:31]))
                c = 2'd2;
            else
                c = 2'd3;
        end
        else begin
            if (!(|v[63:8]))
                c = 2'd0;
            else if (!(|v[63:16]))
                c = 2'd1;
            else if (!(|v[63:32]))
                c = 2'd2;
            else
                c = 2'd3;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/tlv_element_encoder.sv
// TLV element encoder: one request in, its encoded bytes out one per beat.
//
//   channel | signals                       | beat
//   --------+-------------------------------+--------------------------------
//   req     | req_valid, req_ready, req     | one element request
//   rsp     | rsp_valid, rsp_ready, rsp     | one encoded byte or a status
//   cfg     | cfg_we, cfg_index, cfg_data   | one register write
//
// A request takes max(1, bytes) rsp beats, set by the one-byte-wide output
// shifter. The next request is encoded while the current one drains, so
// requests follow each other with no gap while rsp_ready stays high.
// Reset clears the element state and loads the register defaults.
// A stalled rsp holds the shifter; req_ready drops once the input register fills.
`default_nettype none

`include "tlv_element_encoder_assert.svh"

module tlv_element_encoder
#(
    parameter int MAX_DEPTH = tlvenc_pkg::MAX_DEPTH_DEFAULT
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire tlvenc_pkg::req_t                   req,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output tlvenc_pkg::rsp_t                        rsp,
    input  wire logic                               cfg_we,
    input  wire logic [tlvenc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tlvenc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tlvenc_pkg::*;

    localparam int VEC_W = MAX_BYTES * 8;
    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    // registers
    logic [31:0]      impl_profile_reg;
    logic             impl_enable_reg;
    logic [15:0]      capacity_reg;

    logic             hold_valid_reg;
    req_t             hold_reg;

    logic [15:0]      wl_reg, wl_next;
    logic [3:0]       depth_reg, depth_next;
    status_t          err_reg, err_next;
    logic [31:0]      rem_reg, rem_next;

    logic             rec_valid_reg;
    logic [VEC_W-1:0] rec_bytes_reg;
    logic [CNT_W-1:0] rec_left_reg;
    logic             rec_has_bytes_reg;
    status_t          rec_status_reg;
    logic [15:0]      rec_total_reg;

    // encode stage
    logic             load_rec;
    logic             rsp_last;
    logic             tag_small;
    logic             tag_bad;
    logic [7:0]       tag_ctl;
    logic [3:0]       tag_oct;
    logic [63:0]      tag_bytes;
    logic [1:0]       int_c;
    logic [1:0]       str_c;
    logic [1:0]       val_c;
    logic [3:0]       val_w;
    logic [63:0]      val_bits;
    logic [4:0]       etype;
    logic             has_val;
    logic             is_str;
    logic             ct_bad;
    logic [16:0]      tag_end;
    logic [33:0]      val_end;
    logic             tag_fit;
    logic             val_fit;
    logic             byte_fit;
    logic [VEC_W-1:0] elem_vec;

    logic [VEC_W-1:0] cnt_bytes;
    logic [CNT_W-1:0] cnt;
    status_t          out_status;
    logic [15:0]      out_total;

    assign rsp_last  = (rec_left_reg == CNT_W'(1));
    assign load_rec  = hold_valid_reg && (!rec_valid_reg || (rsp_ready && rsp_last));
    assign req_ready = !hold_valid_reg || load_rec;

    // tag form
    always_comb
    begin
        tag_small = (hold_reg.elem_num[31:16] == 16'd0);
        tag_bad   = 1'b0;
        tag_bytes = {32'd0, hold_reg.elem_num};
        if (&hold_reg.elem_prof) begin
            if (&hold_reg.elem_num) begin
                tag_ctl   = TAG_ANON;
                tag_oct   = 4'd0;
                tag_bytes = 64'd0;
            end
            else if (hold_reg.elem_num[31:8] == 24'd0) begin
                tag_ctl = TAG_CONTEXT;
                tag_oct = 4'd1;
            end
            else begin
                tag_ctl = TAG_ANON;
                tag_oct = 4'd0;
                tag_bad = 1'b1;
            end
        end
        else if (hold_reg.elem_prof == 32'd0) begin
            tag_ctl = tag_small ? TAG_COMMON_2 : TAG_COMMON_4;
            tag_oct = tag_small ? 4'd2 : 4'd4;
        end
        else if (impl_enable_reg && (hold_reg.elem_prof == impl_profile_reg)) begin
            tag_ctl = tag_small ? TAG_IMPL_2 : TAG_IMPL_4;
            tag_oct = tag_small ? 4'd2 : 4'd4;
        end
        else begin
            tag_ctl   = tag_small ? TAG_FULL_6 : TAG_FULL_8;
            tag_oct   = tag_small ? 4'd6 : 4'd8;
            // vendor, then profile number, then tag number, each little-endian
            tag_bytes = {hold_reg.elem_num, hold_reg.elem_prof[15:0],
                         hold_reg.elem_prof[31:16]};
        end
    end

    // element type and value field
    always_comb
    begin
        int_c = int_code(hold_reg.value_bits, hold_reg.kind == KIND_SIGNED);
        if (hold_reg.string_length[31:8] == 24'd0)
            str_c = 2'd0;
        else if (hold_reg.string_length[31:16] == 16'd0)
            str_c = 2'd1;
        else
            str_c = 2'd2;
        is_str  = (hold_reg.kind == KIND_TEXT) || (hold_reg.kind == KIND_BYTES);
        has_val = is_str || (hold_reg.kind == KIND_SIGNED) || (hold_reg.kind == KIND_UNSIGNED);
        val_c    = is_str ? str_c : int_c;
        val_w    = 4'd1 << val_c;
        val_bits = is_str ? {32'd0, hold_reg.string_length} : hold_reg.value_bits;
        ct_bad   = (hold_reg.container_type < TYPE_STRUCT) ||
                   (hold_reg.container_type > TYPE_LIST);
        case (hold_reg.kind)
            KIND_BOOL:     etype = hold_reg.bool_value ? (TYPE_BOOL_FALSE + 5'd1)
                                                       : TYPE_BOOL_FALSE;
            KIND_NULL:     etype = TYPE_NULL;
            KIND_SIGNED:   etype = TYPE_SIGNED + 5'(val_c);
            KIND_UNSIGNED: etype = TYPE_UNSIGNED + 5'(val_c);
            KIND_TEXT:     etype = TYPE_UTF8 + 5'(val_c);
            KIND_BYTES:    etype = TYPE_BYTES + 5'(val_c);
            KIND_START:    etype = hold_reg.container_type;
            default:       etype = TYPE_NULL;
        endcase
    end

    // space checks and byte image
    always_comb
    begin
        tag_end  = {1'b0, wl_reg} + 17'd1 + 17'(tag_oct);
        val_end  = 34'(tag_end) + 34'(val_w) +
                   (is_str ? 34'(hold_reg.string_length) : 34'd0);
        tag_fit  = tag_end <= {1'b0, capacity_reg};
        val_fit  = val_end <= {18'd0, capacity_reg};
        byte_fit = wl_reg < capacity_reg;
        elem_vec = (VEC_W'(val_bits) << ({tag_oct, 3'b000} + 7'd8)) |
                   (VEC_W'(tag_bytes) << 8) |
                   VEC_W'(tag_ctl | {3'b000, etype});
    end

    // request outcome
    always_comb
    begin
        wl_next    = wl_reg;
        depth_next = depth_reg;
        err_next   = err_reg;
        rem_next   = rem_reg;
        cnt        = '0;
        cnt_bytes  = elem_vec;
        out_total  = 16'd0;
        out_status = err_reg;
        if (hold_reg.kind == KIND_FINISH) begin
            if (err_reg != STATUS_OK)
                out_status = err_reg;
            else if ((depth_reg != 4'd0) || (rem_reg != 32'd0))
                out_status = STATUS_BAD_STATE;
            else begin
                out_status = STATUS_OK;
                out_total  = wl_reg;
            end
            wl_next    = 16'd0;
            depth_next = 4'd0;
            err_next   = STATUS_OK;
            rem_next   = 32'd0;
        end
        else begin
            if (err_reg != STATUS_OK) begin
                err_next = err_reg;
            end
            else if (hold_reg.kind > KIND_FINISH) begin
                err_next = STATUS_INVALID;
            end
            else if ((rem_reg != 32'd0) && (hold_reg.kind != KIND_PAYLOAD)) begin
                err_next = STATUS_BAD_STATE;
            end
            else begin
                case (hold_reg.kind)
                    KIND_PAYLOAD:
                    begin
                        if (rem_reg == 32'd0)
                            err_next = STATUS_BAD_STATE;
                        else if (!byte_fit)
                            err_next = STATUS_NO_SPACE;
                        else begin
                            cnt       = CNT_W'(1);
                            cnt_bytes = VEC_W'(hold_reg.payload_byte);
                            wl_next   = wl_reg + 16'd1;
                            rem_next  = rem_reg - 32'd1;
                        end
                    end
                    KIND_END:
                    begin
                        if (depth_reg == 4'd0)
                            err_next = STATUS_BAD_STATE;
                        else if (!byte_fit)
                            err_next = STATUS_NO_SPACE;
                        else begin
                            cnt        = CNT_W'(1);
                            cnt_bytes  = VEC_W'(END_OF_CONTAINER);
                            wl_next    = wl_reg + 16'd1;
                            depth_next = depth_reg - 4'd1;
                        end
                    end
                    KIND_BOOL, KIND_NULL, KIND_SIGNED, KIND_UNSIGNED,
                    KIND_TEXT, KIND_BYTES, KIND_START:
                    begin
                        if ((hold_reg.kind == KIND_START) && ct_bad)
                            err_next = STATUS_INVALID;
                        else if ((hold_reg.kind == KIND_START) &&
                                 (depth_reg >= 4'(MAX_DEPTH)))
                            err_next = STATUS_TOO_DEEP;
                        else if (tag_bad)
                            err_next = STATUS_INVALID;
                        else if (!tag_fit)
                            err_next = STATUS_NO_SPACE;
                        else begin
                            // control and tag stay written even if the value misses
                            cnt     = CNT_W'(1) + CNT_W'(tag_oct);
                            wl_next = tag_end[15:0];
                            if (has_val) begin
                                if (!val_fit)
                                    err_next = STATUS_NO_SPACE;
                                else begin
                                    cnt     = CNT_W'(1) + CNT_W'(tag_oct) + CNT_W'(val_w);
                                    wl_next = tag_end[15:0] + 16'(val_w);
                                    if (is_str)
                                        rem_next = hold_reg.string_length;
                                end
                            end
                            if (hold_reg.kind == KIND_START)
                                depth_next = depth_reg + 4'd1;
                        end
                    end
                    default:
                    begin
                        err_next = STATUS_INVALID;
                    end
                endcase
            end
            out_status = err_next;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            impl_profile_reg <= 32'd0;
            impl_enable_reg  <= 1'b0;
            capacity_reg     <= 16'hFFFF;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_IMPLICIT_PROFILE: impl_profile_reg <= cfg_data[31:0];
                CFG_IMPLICIT_ENABLE:  impl_enable_reg  <= cfg_data[0];
                CFG_CAPACITY:         capacity_reg     <= cfg_data[15:0];
                default:              impl_enable_reg  <= impl_enable_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (req_ready)
            hold_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            hold_reg <= req;
    end

    // element state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wl_reg    <= 16'd0;
            depth_reg <= 4'd0;
            err_reg   <= STATUS_OK;
            rem_reg   <= 32'd0;
        end
        else if (load_rec) begin
            wl_reg    <= wl_next;
            depth_reg <= depth_next;
            err_reg   <= err_next;
            rem_reg   <= rem_next;
        end
    end

    // output shifter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rec_valid_reg <= 1'b0;
            rec_left_reg  <= '0;
        end
        else if (load_rec) begin
            rec_valid_reg <= 1'b1;
            rec_left_reg  <= (cnt == '0) ? CNT_W'(1) : cnt;
        end
        else if (rsp_valid && rsp_ready) begin
            rec_valid_reg <= !rsp_last;
            rec_left_reg  <= rec_left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rec) begin
            rec_bytes_reg     <= cnt_bytes;
            rec_has_bytes_reg <= (cnt != '0);
            rec_status_reg    <= out_status;
            rec_total_reg     <= out_total;
        end
        else if (rsp_valid && rsp_ready) begin
            rec_bytes_reg <= rec_bytes_reg >> 8;
        end
    end

    assign rsp_valid         = rec_valid_reg;
    assign rsp.out_byte      = rec_has_bytes_reg ? rec_bytes_reg[7:0] : 8'd0;
    assign rsp.byte_valid    = rec_has_bytes_reg;
    assign rsp.last          = rsp_last;
    assign rsp.status        = rec_status_reg;
    assign rsp.total_length  = rec_total_reg;

    `TLV_ASSERT_ALWAYS(a_depth_bound, depth_reg <= 4'(MAX_DEPTH))
    `TLV_ASSERT_IMPLY(a_left_nonzero, rec_valid_reg,
        (rec_left_reg != '0) && (rec_left_reg <= CNT_W'(MAX_BYTES)))
    `TLV_ASSERT_IMPLY(a_empty_is_last, rec_valid_reg && !rec_has_bytes_reg, rsp_last)
    `TLV_ASSERT_NEXT(a_error_sticky,
        (err_reg != STATUS_OK) && !(load_rec && (hold_reg.kind == KIND_FINISH)),
        $stable(err_reg))

endmodule

`default_nettype wire
